// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the byte decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/pdcb_pkg.sv
// ----------------------------------------------------------------------------
// pdcb_pkg
// Constants and types shared by the pad dual code byte decoder modules.
// ----------------------------------------------------------------------------
package pdcb_pkg;

    // Geometry of one bit group.
    localparam int LANES  = 4;
    localparam int WORD_W = 32;
    localparam int IN_W   = 3 * LANES * WORD_W;

    // Groups per decoded byte and the counter widths that follow.
    localparam int GROUPS     = 8;
    localparam int GROUP_W    = 3;
    localparam int TOTAL_W    = 5;
    localparam int BYTE_W     = 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [GROUP_W-1:0] LAST_GROUP   = GROUP_W'(GROUPS - 1);
    localparam logic [TOTAL_W-1:0] VALID_TOTAL  = TOTAL_W'(GROUPS);

    // Alternating bit masks applied to the pad words.
    localparam logic [WORD_W-1:0] MASK_ODD_BITS  = 32'h5555_5555;
    localparam logic [WORD_W-1:0] MASK_EVEN_BITS = 32'hAAAA_AAAA;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [LANES-1:0][WORD_W-1:0] lane_words_t;

    // Status from the merge stage to the byte accumulator.
    typedef struct packed {
        logic word0_nz;
        logic word1_nz;
    } merge_result_t;

endpackage

// File: src/pdcb_lane.sv
// ----------------------------------------------------------------------------
// pdcb_lane
// One decoding lane: forms both masked candidates for one cipher word.
// ----------------------------------------------------------------------------
module pdcb_lane (
    input  pdcb_pkg::word_t cipher_word,
    input  pdcb_pkg::word_t pad_even,
    input  pdcb_pkg::word_t pad_odd,
    output pdcb_pkg::word_t cand_a,
    output pdcb_pkg::word_t cand_b
);

    // Candidate A keeps the even pad on the upper bit of each pair, B swaps the masks.
    assign cand_a = cipher_word ^ (pad_even & pdcb_pkg::MASK_EVEN_BITS)
                                ^ (pad_odd  & pdcb_pkg::MASK_ODD_BITS);
    assign cand_b = cipher_word ^ (pad_even & pdcb_pkg::MASK_ODD_BITS)
                                ^ (pad_odd  & pdcb_pkg::MASK_EVEN_BITS);

endmodule

// File: src/pdcb_merge.sv
// ----------------------------------------------------------------------------
// pdcb_merge
// Combines the lane candidates into word0 and word1 and flags nonzero words.
// ----------------------------------------------------------------------------
module pdcb_merge (
    input  pdcb_pkg::lane_words_t   lane_a,
    input  pdcb_pkg::lane_words_t   lane_b,
    output pdcb_pkg::merge_result_t result
);

    pdcb_pkg::word_t word0;
    pdcb_pkg::word_t word1;

    // OR the candidates of all lanes together.
    always_comb
    begin
        word0 = '0;
        word1 = '0;
        for (int k = 0; k < pdcb_pkg::LANES; k++)
        begin
            word0 = word0 | lane_a[k];
            word1 = word1 | lane_b[k];
        end
    end

    // A word counts when any of its bits is set.
    assign result.word0_nz = |word0;
    assign result.word1_nz = |word1;

endmodule

// File: src/pad_dual_code_byte_decoder.sv
// ----------------------------------------------------------------------------
// pad_dual_code_byte_decoder
// Decodes one byte from eight bit groups of cipher and pad words.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one bit group per beat on s_axis_tdata: four
// cipher words, then the even and odd pad words of lanes 0 to 3. Four lanes
// form the masked candidates of a group in parallel and a merge stage ORs
// them into two words, so a group is accepted every cycle unless a final group waits on the output.
// After every eighth accepted beat one result beat appears on the master
// channel, in the cycle after that eighth beat: the decoded byte on
// m_axis_tdata (bit 0 from the first group) and the count check on
// m_axis_tuser. The result sits in a single output register.
// If the receiver stalls, the first seven groups of the next byte are still
// accepted; the eighth waits until the held result is taken, unless it is
// taken in the same cycle.
// Reset clears the group counter, the nonzero count, the gathered bits and
// the output valid flag; decoding starts at bit 0 of a new byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pad_dual_code_byte_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    // Slave side, tdata from the lowest bit up: cipher_word_0..3, pad_even_0,
    // pad_odd_0, pad_even_1, pad_odd_1, pad_even_2, pad_odd_2, pad_even_3, pad_odd_3.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pdcb_pkg::IN_W-1:0]       s_axis_tdata,
    // Master side, tdata: plain_byte. tuser: byte_valid.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pdcb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [0:0]                      m_axis_tuser
);

    pdcb_pkg::lane_words_t   lane_a;
    pdcb_pkg::lane_words_t   lane_b;
    pdcb_pkg::merge_result_t merge_res;

    logic [pdcb_pkg::GROUP_W-1:0] group_reg, group_next;
    logic [pdcb_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [pdcb_pkg::BYTE_W-1:0]  bits_reg,  bits_next;
    logic                         out_valid_reg, out_valid_next;
    logic [pdcb_pkg::BYTE_W-1:0]  out_byte_reg,  out_byte_next;
    logic                         out_ok_reg,    out_ok_next;

    logic [pdcb_pkg::TOTAL_W-1:0] total_sum;
    logic [pdcb_pkg::BYTE_W-1:0]  bits_sum;
    logic                         last_group;
    logic                         in_beat;
    logic                         out_beat;

    // Lanes: each one takes its cipher word and its pad word pair.
    for (genvar k = 0; k < pdcb_pkg::LANES; k++)
    begin : g_lane
        pdcb_lane u_lane (
            .cipher_word (s_axis_tdata[k*pdcb_pkg::WORD_W +: pdcb_pkg::WORD_W]),
            .pad_even    (s_axis_tdata[(pdcb_pkg::LANES + 2*k)*pdcb_pkg::WORD_W
                                       +: pdcb_pkg::WORD_W]),
            .pad_odd     (s_axis_tdata[(pdcb_pkg::LANES + 2*k + 1)*pdcb_pkg::WORD_W
                                       +: pdcb_pkg::WORD_W]),
            .cand_a      (lane_a[k]),
            .cand_b      (lane_b[k])
        );
    end

    pdcb_merge u_merge (
        .lane_a (lane_a),
        .lane_b (lane_b),
        .result (merge_res)
    );

    // Handshakes: only the final group of a byte needs room in the output register.
    assign last_group    = (group_reg == pdcb_pkg::LAST_GROUP);
    assign s_axis_tready = !last_group || !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = out_valid_reg && m_axis_tready;

    // Running count and gathered bits including the current group.
    always_comb
    begin
        total_sum = total_reg
                  + pdcb_pkg::TOTAL_W'(merge_res.word0_nz)
                  + pdcb_pkg::TOTAL_W'(merge_res.word1_nz);
        bits_sum  = bits_reg;
        bits_sum[group_reg] = bits_reg[group_reg] | !merge_res.word1_nz;
    end

    // Per-byte state and output register updates.
    always_comb
    begin
        group_next     = group_reg;
        total_next     = total_reg;
        bits_next      = bits_reg;
        out_valid_next = out_valid_reg && !out_beat;
        out_byte_next  = out_byte_reg;
        out_ok_next    = out_ok_reg;
        if (in_beat)
        begin
            if (last_group)
            begin
                group_next     = '0;
                total_next     = '0;
                bits_next      = '0;
                out_valid_next = 1'b1;
                out_byte_next  = bits_sum;
                out_ok_next    = (total_sum == pdcb_pkg::VALID_TOTAL);
            end
            else
            begin
                group_next = group_reg + 1'b1;
                total_next = total_sum;
                bits_next  = bits_sum;
            end
        end
    end

    // Control state with asynchronous reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg     <= '0;
            total_reg     <= '0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            group_reg     <= group_next;
            total_reg     <= total_next;
            bits_reg      <= bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tuser[0] = out_ok_reg;

    // Each earlier group adds at most two nonzero words.
    `ASSERT_ALWAYS(a_total_bound, clk, rst_n,
        total_reg <= {1'b0, group_reg, 1'b0})
    // The final group of a byte always leaves a result waiting.
    `ASSERT_NEXT(a_last_loads_out, clk, rst_n, in_beat && last_group,
        out_valid_reg && group_reg == '0)
    // A held result that is not taken blocks the final group.
    `ASSERT_IMPLY(a_no_overwrite, clk, rst_n,
        out_valid_reg && !m_axis_tready && last_group, !s_axis_tready)
    // Earlier groups advance the group counter by one.
    `ASSERT_NEXT(a_group_step, clk, rst_n, in_beat && !last_group,
        group_reg == $past(group_reg) + 1'b1)

endmodule

// File: verif/pad_dual_code_byte_decoder_tb.sv
// ----------------------------------------------------------------------------
// pad_dual_code_byte_decoder_tb
// Self-checking bench for the byte decoder. A queue of bit groups feeds a
// stream driver, and a monitor predicts each decoded byte and its count check
// from the accepted groups. It compares every result beat against the oldest
// prediction. Both sides idle in random bursts, and the receiver also stalls
// for long stretches to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pad_dual_code_byte_decoder_tb;

    localparam int NUM_GROUPS  = 750;
    localparam int CALM_ITEMS  = 100;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // Markers that steer the driver and the receiver at chosen groups.
    typedef enum logic [1:0] {
        MARK_NONE,
        MARK_STALL,
        MARK_DRAIN
    } mark_t;

    typedef struct {
        pdcb_pkg::lane_words_t cipher;
        pdcb_pkg::lane_words_t pad_even;
        pdcb_pkg::lane_words_t pad_odd;
        mark_t                 mark;
    } group_t;

    typedef struct packed {
        logic [pdcb_pkg::BYTE_W-1:0] plain;
        logic                        valid;
    } byte_result_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pdcb_pkg::IN_W-1:0]       s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [pdcb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]                      m_axis_tuser;

    group_t       group_q[$];
    byte_result_t byte_expect_q[$];

    // Predictor state for the byte being gathered.
    logic [pdcb_pkg::GROUP_W-1:0] pred_group = '0;
    logic [pdcb_pkg::TOTAL_W-1:0] pred_total = '0;
    logic [pdcb_pkg::BYTE_W-1:0]  pred_bits  = '0;

    logic in_taken      = 1'b0;
    logic calm          = 1'b0;
    int   stall_req_cnt = 0;
    int   stall_seen    = 0;
    int   src_gap       = 0;
    int   sink_hold     = 0;
    int   cycle_cnt     = 0;
    int   mismatches    = 0;
    int   groups_taken  = 0;
    int   bytes_checked = 0;
    int   bytes_invalid = 0;

    pad_dual_code_byte_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    always #5 clk = ~clk;

    // Places the words of a group into the slave tdata layout.
    function automatic logic [pdcb_pkg::IN_W-1:0] pack_group(input group_t g);
        logic [pdcb_pkg::IN_W-1:0] data;
        data = '0;
        for (int k = 0; k < pdcb_pkg::LANES; k++)
        begin
            data[k*pdcb_pkg::WORD_W +: pdcb_pkg::WORD_W] = g.cipher[k];
            data[(pdcb_pkg::LANES + 2*k)*pdcb_pkg::WORD_W +: pdcb_pkg::WORD_W] =
                g.pad_even[k];
            data[(pdcb_pkg::LANES + 2*k + 1)*pdcb_pkg::WORD_W +: pdcb_pkg::WORD_W] =
                g.pad_odd[k];
        end
        return data;
    endfunction

    // Advances the predicted byte by one accepted group and queues the
    // decoded byte once the eighth group of the byte has arrived.
    task automatic decode_group(input logic [pdcb_pkg::IN_W-1:0] data);
        pdcb_pkg::word_t cand_a;
        pdcb_pkg::word_t cand_b;
        pdcb_pkg::word_t c;
        pdcb_pkg::word_t pe;
        pdcb_pkg::word_t po;
        byte_result_t    res;
        cand_a = '0;
        cand_b = '0;
        for (int k = 0; k < pdcb_pkg::LANES; k++)
        begin
            c  = data[k*pdcb_pkg::WORD_W +: pdcb_pkg::WORD_W];
            pe = data[(pdcb_pkg::LANES + 2*k)*pdcb_pkg::WORD_W +: pdcb_pkg::WORD_W];
            po = data[(pdcb_pkg::LANES + 2*k + 1)*pdcb_pkg::WORD_W +: pdcb_pkg::WORD_W];
            cand_a |= c ^ (pe & pdcb_pkg::MASK_EVEN_BITS) ^ (po & pdcb_pkg::MASK_ODD_BITS);
            cand_b |= c ^ (pe & pdcb_pkg::MASK_ODD_BITS) ^ (po & pdcb_pkg::MASK_EVEN_BITS);
        end
        pred_total = pred_total + pdcb_pkg::TOTAL_W'(cand_a != '0)
                                + pdcb_pkg::TOTAL_W'(cand_b != '0);
        if (cand_b == '0)
        begin
            pred_bits[pred_group] = 1'b1;
        end
        if (pred_group == pdcb_pkg::LAST_GROUP)
        begin
            res.plain = pred_bits;
            res.valid = (pred_total == pdcb_pkg::VALID_TOTAL);
            byte_expect_q.push_back(res);
            pred_group = '0;
            pred_total = '0;
            pred_bits  = '0;
        end
        else
        begin
            pred_group = pred_group + 1'b1;
        end
    endtask

    // A group that decodes to the given bit with exactly one nonzero word.
    function automatic group_t make_coded(input logic bit_val);
        group_t g;
        for (int k = 0; k < pdcb_pkg::LANES; k++)
        begin
            g.pad_even[k] = $urandom;
            g.pad_odd[k]  = $urandom;
            if (bit_val)
            begin
                g.cipher[k] = (g.pad_even[k] & pdcb_pkg::MASK_ODD_BITS)
                            ^ (g.pad_odd[k] & pdcb_pkg::MASK_EVEN_BITS);
            end
            else
            begin
                g.cipher[k] = (g.pad_even[k] & pdcb_pkg::MASK_EVEN_BITS)
                            ^ (g.pad_odd[k] & pdcb_pkg::MASK_ODD_BITS);
            end
        end
        g.mark = MARK_NONE;
        return g;
    endfunction

    // A group whose candidates are both zero: equal pads, cipher matching.
    function automatic group_t make_silent();
        group_t g;
        for (int k = 0; k < pdcb_pkg::LANES; k++)
        begin
            g.pad_even[k] = $urandom;
            g.pad_odd[k]  = g.pad_even[k];
            g.cipher[k]   = g.pad_even[k];
        end
        g.mark = MARK_NONE;
        return g;
    endfunction

    // A group of unrelated words, almost always two nonzero candidates.
    function automatic group_t make_noise();
        group_t g;
        for (int k = 0; k < pdcb_pkg::LANES; k++)
        begin
            g.cipher[k]   = $urandom;
            g.pad_even[k] = $urandom;
            g.pad_odd[k]  = $urandom;
        end
        g.mark = MARK_NONE;
        return g;
    endfunction

    // Queues eight well-formed groups that carry the given byte.
    task automatic push_byte(input logic [pdcb_pkg::BYTE_W-1:0] value);
        for (int i = 0; i < pdcb_pkg::GROUPS; i++)
        begin
            group_q.push_back(make_coded(value[i]));
        end
    endtask

    // Queues a byte in which one silent group and one noise group balance
    // each other, so the total still meets the count check.
    task automatic push_balanced_byte();
        int quiet_pos;
        int noisy_pos;
        quiet_pos = $urandom_range(0, pdcb_pkg::GROUPS - 1);
        noisy_pos = (quiet_pos + $urandom_range(1, pdcb_pkg::GROUPS - 1)) % pdcb_pkg::GROUPS;
        for (int i = 0; i < pdcb_pkg::GROUPS; i++)
        begin
            if (i == quiet_pos)
            begin
                group_q.push_back(make_silent());
            end
            else if (i == noisy_pos)
            begin
                group_q.push_back(make_noise());
            end
            else
            begin
                group_q.push_back(make_coded(1'($urandom_range(0, 1))));
            end
        end
    endtask

    // Reports a field mismatch; only the first few are printed.
    task automatic note_mismatch(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("mismatch %0d on %s: expected 0x%0h, got 0x%0h (beat %0d)",
                     mismatches, field, want, got, bytes_checked);
        end
    endtask

    // Slave driver: holds a beat until it is taken, then offers the next
    // queued group after an optional random gap.
    always @(negedge clk)
    begin : drive_groups
        logic                      nxt_valid;
        logic [pdcb_pkg::IN_W-1:0] nxt_data;
        group_t                    cur;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (rst_n && !(s_axis_tvalid && !in_taken))
        begin
            nxt_valid = 1'b0;
            if (src_gap > 0)
            begin
                src_gap--;
            end
            else if (group_q.size() > 0)
            begin
                if (group_q[0].mark == MARK_DRAIN && byte_expect_q.size() > 0)
                begin
                    // Sender pauses until every predicted byte has come out.
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    src_gap = $urandom_range(0, 11);
                end
                else
                begin
                    cur = group_q.pop_front();
                    if (cur.mark == MARK_STALL)
                    begin
                        stall_req_cnt <= stall_req_cnt + 1;
                    end
                    nxt_valid = 1'b1;
                    nxt_data  = pack_group(cur);
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // Master-side receiver: random short stalls plus long hold-offs on request.
    always @(negedge clk)
    begin : drive_ready
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (!rst_n)
        begin
            nxt_ready = 1'b0;
        end
        else if (stall_seen != stall_req_cnt)
        begin
            stall_seen = stall_req_cnt;
            sink_hold  = LONG_HOLD - 1;
            nxt_ready  = 1'b0;
        end
        else if (sink_hold > 0)
        begin
            sink_hold--;
            nxt_ready = 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            sink_hold = $urandom_range(0, 11);
            nxt_ready = 1'b0;
        end
        m_axis_tready <= nxt_ready;
    end

    // Monitor: checks result beats, then feeds accepted groups to the predictor.
    always @(posedge clk)
    begin : watch_ports
        byte_result_t want;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            calm     <= (group_q.size() < CALM_ITEMS);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (byte_expect_q.size() == 0)
                begin
                    note_mismatch("unexpected result beat", 0, int'(m_axis_tdata));
                end
                else
                begin
                    want = byte_expect_q.pop_front();
                    if (m_axis_tdata !== want.plain)
                    begin
                        note_mismatch("plain_byte", int'(want.plain), int'(m_axis_tdata));
                    end
                    if (m_axis_tuser[0] !== want.valid)
                    begin
                        note_mismatch("byte_valid", int'(want.valid), int'(m_axis_tuser[0]));
                    end
                    if (!want.valid)
                    begin
                        bytes_invalid++;
                    end
                end
                bytes_checked++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_group(s_axis_tdata);
                groups_taken++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus plan, reset and end of run.
    initial
    begin : run_plan
        group_t g;
        int     kind;
        int     extra;

        // Directed: all-zero and all-ones words, coded groups to end that byte, then one well-formed byte.
        g.cipher   = '0;
        g.pad_even = '0;
        g.pad_odd  = '0;
        g.mark     = MARK_NONE;
        group_q.push_back(g);
        g.cipher   = '1;
        g.pad_even = '1;
        g.pad_odd  = '1;
        group_q.push_back(g);
        for (int i = 0; i < pdcb_pkg::GROUPS - 2; i++)
        begin
            group_q.push_back(make_coded(i[0]));
        end
        push_byte(8'hA5);
        // A byte with a silent group and a noise group that balance out.
        push_balanced_byte();

        // Random part: mostly well-formed bytes, with noise and shifted phase.
        while (group_q.size() < NUM_GROUPS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                push_byte(pdcb_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            else if (kind == 6)
            begin
                push_balanced_byte();
            end
            else if (kind == 7)
            begin
                for (int i = 0; i < pdcb_pkg::GROUPS; i++)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        group_q.push_back(make_noise());
                    end
                    else
                    begin
                        group_q.push_back(make_silent());
                    end
                end
            end
            else
            begin
                // A few loose groups that shift the byte boundary.
                extra = $urandom_range(1, 3);
                for (int i = 0; i < extra; i++)
                begin
                    group_q.push_back(make_noise());
                end
            end
        end
        group_q[180].mark = MARK_STALL;
        group_q[320].mark = MARK_DRAIN;
        group_q[470].mark = MARK_STALL;
        group_q[610].mark = MARK_DRAIN;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (group_q.size() != 0 || s_axis_tvalid || byte_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d bit groups accepted, %0d bytes checked (%0d flagged invalid)",
                 groups_taken, bytes_checked, bytes_invalid);
        $display("summary: %0d mismatches, %0d long receiver stalls, %0d cycles",
                 mismatches, stall_req_cnt, cycle_cnt);
        if (mismatches == 0 && byte_expect_q.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
